### rtl/benes_pkg.sv
// ----------------------------------------------------------------------------
// benes_pkg
// Shared constants, wiring table and control types for the Benes route setup.
// ----------------------------------------------------------------------------
package benes_pkg;

  localparam int PORTS        = 8;
  localparam int STAGES       = 5;
  localparam int SW_PER_STAGE = PORTS / 2;
  localparam int PORT_W       = $clog2(PORTS);
  localparam int SW_W         = $clog2(SW_PER_STAGE);

  typedef logic [PORT_W-1:0] port_t;
  typedef logic [SW_W-1:0]   sw_idx_t;
  typedef logic [STAGES-1:0] vec_t;
  typedef logic [1:0]        sw_set_t;

  localparam sw_set_t SW_UNSET   = 2'd0;
  localparam sw_set_t SW_DIRECT  = 2'd1;
  localparam sw_set_t SW_CROSSED = 2'd2;

  // next port for [stage][switch][switch output]
  localparam port_t WIRING [STAGES][SW_PER_STAGE][2] = '{
    '{ '{3'd0, 3'd4}, '{3'd1, 3'd5}, '{3'd2, 3'd6}, '{3'd3, 3'd7} },
    '{ '{3'd0, 3'd2}, '{3'd1, 3'd3}, '{3'd4, 3'd6}, '{3'd5, 3'd7} },
    '{ '{3'd0, 3'd2}, '{3'd1, 3'd3}, '{3'd4, 3'd6}, '{3'd5, 3'd7} },
    '{ '{3'd0, 3'd2}, '{3'd4, 3'd6}, '{3'd1, 3'd3}, '{3'd5, 3'd7} },
    '{ '{3'd0, 3'd1}, '{3'd2, 3'd3}, '{3'd4, 3'd5}, '{3'd6, 3'd7} }
  };

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic emit;
    logic found;
  } benes_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } benes_stat_t;

endpackage

### rtl/benes_dp.sv
// ----------------------------------------------------------------------------
// benes_dp
// Switch table, candidate vector register, path trace and result register.
// ----------------------------------------------------------------------------
module benes_dp import benes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  port_t       source_port_i,
  input  port_t       dest_port_i,
  input  benes_cmd_t  cmd_i,
  output benes_stat_t stat_o,
  output logic        done_o,
  output logic        found_o,
  output vec_t        setting_vector_o
);

  port_t   src_q, dst_q;
  vec_t    vec_q;
  sw_set_t tbl_q [STAGES][SW_PER_STAGE];
  logic    done_q, found_q;
  vec_t    res_vec_q;

  sw_idx_t sel_sw [STAGES];
  sw_set_t want   [STAGES];
  logic    ok;
  port_t   end_port;

  always_comb begin
    port_t   port;
    logic    bit_s;
    sw_idx_t sw;
    sw_set_t have;
    port = src_q;
    ok   = 1'b1;
    for (int s = 0; s < STAGES; s++) begin
      bit_s     = vec_q[STAGES-1-s];
      sw        = port[PORT_W-1:1];
      sel_sw[s] = sw;
      want[s]   = bit_s ? SW_CROSSED : SW_DIRECT;
      have      = tbl_q[s][sw];
      if (have != SW_UNSET && have != want[s]) begin
        ok = 1'b0;
      end
      port = WIRING[s][sw][bit_s ^ port[0]];
    end
    end_port = port;
  end

  assign stat_o.hit  = ok && (end_port == dst_q);
  assign stat_o.last = &vec_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      src_q <= source_port_i;
      dst_q <= dest_port_i;
      vec_q <= '0;
    end else if (cmd_i.step) begin
      vec_q <= vec_q + vec_t'(1);
    end
    if (cmd_i.emit) begin
      found_q   <= cmd_i.found;
      res_vec_q <= cmd_i.found ? vec_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      for (int s = 0; s < STAGES; s++) begin
        for (int w = 0; w < SW_PER_STAGE; w++) begin
          tbl_q[s][w] <= SW_UNSET;
        end
      end
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.commit) begin
        for (int s = 0; s < STAGES; s++) begin
          tbl_q[s][sel_sw[s]] <= want[s];
        end
      end
    end
  end

  assign done_o           = done_q;
  assign found_o          = found_q;
  assign setting_vector_o = res_vec_q;

endmodule

### rtl/benes_ctrl.sv
// ----------------------------------------------------------------------------
// benes_ctrl
// Sequencer: load a request, walk candidate vectors, commit or report a miss.
// ----------------------------------------------------------------------------
module benes_ctrl import benes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  benes_stat_t stat_i,
  output benes_cmd_t  cmd_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        priority if (stat_i.hit) begin
          cmd_o.commit = 1'b1;
          cmd_o.emit   = 1'b1;
          cmd_o.found  = 1'b1;
          state_d      = ST_IDLE;
        end else if (stat_i.last) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

### rtl/benes_route_setup_core.sv
// ----------------------------------------------------------------------------
// benes_route_setup_core
// Circuit setup for an 8-port, 5-stage Benes fabric with a 20-switch table.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The block first
// latches the request, then tests one 5-bit setting vector per cycle, in
// ascending order, with the whole five-stage path trace and the switch-table
// conflict check done combinationally. found_o / setting_vector_o are
// registered in the cycle after the deciding vector and hold until the next
// result; done_o flags them and is high for a single cycle. The receiver
// cannot stall; capture the result while done_o is high. busy drops in the
// done_o cycle, so the next transaction may start at that edge. Reset leaves
// every switch unset.
module benes_route_setup_core import benes_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  port_t source_port_i,
  input  port_t dest_port_i,
  output logic  done_o,
  output logic  found_o,
  output vec_t  setting_vector_o
);

  benes_cmd_t  cmd;
  benes_stat_t stat;

  benes_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  benes_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .source_port_i    (source_port_i),
    .dest_port_i      (dest_port_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .done_o           (done_o),
    .found_o          (found_o),
    .setting_vector_o (setting_vector_o)
  );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Benes route setup core.
// ----------------------------------------------------------------------------
// Drives route requests through the start/busy handshake and keeps a shadow
// switch table that is updated in the same order as the requests are taken.
// For each request it searches the 32 setting vectors in ascending order and
// queues the expected outcome. Every done_o strobe is checked against the
// oldest queued outcome. The run covers directed corner requests, then random
// requests with no sender gaps, with heavy gaps, and with moderate gaps, plus
// one full drain before new work is sent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import benes_pkg::*;

  typedef struct packed {
    logic found;
    vec_t vec;
  } route_result_t;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  port_t source_port_i;
  port_t dest_port_i;
  logic  done_o;
  logic  found_o;
  vec_t  setting_vector_o;

  sw_set_t       shadow_switches [STAGES*SW_PER_STAGE];
  route_result_t route_expect_q[$];
  route_result_t head_route;
  int            sender_idle_pct;
  int            errors_seen;

  benes_route_setup_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .source_port_i   (source_port_i),
    .dest_port_i     (dest_port_i),
    .done_o          (done_o),
    .found_o         (found_o),
    .setting_vector_o(setting_vector_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Search vectors in ascending order; commit the first conflict-free one that reaches dst.
  function automatic route_result_t plan_route(port_t src, port_t dst);
    route_result_t res;
    vec_t          cand;
    port_t         p;
    logic          ok;
    int            used [STAGES];
    sw_set_t       want;
    res = '0;
    for (int v = 0; v < (1 << STAGES); v++) begin
      cand = vec_t'(v);
      p = src;
      for (int s = 0; s < STAGES; s++) begin
        used[s] = s * SW_PER_STAGE + int'(p[PORT_W-1:1]);
        p = WIRING[s][p[PORT_W-1:1]][cand[STAGES-1-s] ^ p[0]];
      end
      if (p == dst) begin
        ok = 1'b1;
        for (int s = 0; s < STAGES; s++) begin
          want = cand[STAGES-1-s] ? SW_CROSSED : SW_DIRECT;
          if (shadow_switches[used[s]] != SW_UNSET && shadow_switches[used[s]] != want)
            ok = 1'b0;
        end
        if (ok) begin
          for (int s = 0; s < STAGES; s++)
            shadow_switches[used[s]] = cand[STAGES-1-s] ? SW_CROSSED : SW_DIRECT;
          res.found = 1'b1;
          res.vec   = cand;
          return res;
        end
      end
    end
    return res;
  endfunction

  task automatic send_route(port_t src, port_t dst);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start         <= 1'b1;
    source_port_i <= src;
    dest_port_i   <= dst;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    route_expect_q.push_back(plan_route(src, dst));
  endtask

  task automatic drain_routes();
    @(negedge clk_i);
    start <= 1'b0;
    while (route_expect_q.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (route_expect_q.size() == 0) begin
        $error("unexpected result: found %0d, setting_vector %0d", found_o,
               setting_vector_o);
        errors_seen++;
      end else begin
        head_route = route_expect_q.pop_front();
        if (found_o !== head_route.found) begin
          $error("found: expected %0d, got %0d", head_route.found, found_o);
          errors_seen++;
        end
        if (setting_vector_o !== head_route.vec) begin
          $error("setting_vector: expected %0d, got %0d", head_route.vec,
                 setting_vector_o);
          errors_seen++;
        end
      end
    end
  end

  task automatic test_directed();
    sender_idle_pct = 0;
    send_route(3'd0, 3'd0);
    send_route(3'd0, 3'd0);
    send_route(3'd7, 3'd7);
    send_route(3'd0, 3'd7);
    send_route(3'd7, 3'd0);
    send_route(3'd3, 3'd4);
    send_route(3'd4, 3'd3);
    send_route(3'd7, 3'd7);
    for (int i = 0; i < PORTS; i++)
      send_route(port_t'(i), ~port_t'(i));
    for (int i = 0; i < PORTS; i += 2)
      send_route(port_t'(i), port_t'(i + 1));
  endtask

  task automatic test_random(int idle_pct, int count);
    sender_idle_pct = idle_pct;
    repeat (count)
      send_route(port_t'($urandom_range(PORTS - 1)), port_t'($urandom_range(PORTS - 1)));
  endtask

  task automatic test_pause_until_drained();
    test_random(0, 20);
    drain_routes();
    test_random(0, 20);
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    source_port_i   = '0;
    dest_port_i     = '0;
    sender_idle_pct = 0;
    errors_seen     = 0;
    for (int i = 0; i < STAGES * SW_PER_STAGE; i++)
      shadow_switches[i] = SW_UNSET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(0, 430);
    test_random(64, 430);
    test_pause_until_drained();
    test_random(33, 430);

    drain_routes();
    repeat (40) @(posedge clk_i);
    if (route_expect_q.size() != 0) begin
      $error("%0d results never arrived", route_expect_q.size());
      errors_seen++;
    end
    if (errors_seen == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/benes_pkg.sv
rtl/benes_dp.sv
rtl/benes_ctrl.sv
rtl/benes_route_setup_core.sv
test/tb.sv
